/* design/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bis check failed");

// Clocked assertion that also watches the reset cycles
`define CHK_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bis check failed");

`endif

/* design/bis_pkg.sv */
package bis_pkg;

   // Stream payload widths
   localparam int DATA_W      = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DESCENDING = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED     = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PROBE,
      ST_SHIFT,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

/* design/binary_insertion_sort_top.sv */
// Channel   Dir  tdata              tlast          tuser
// req_      in   item_value [31:0]  last_item      -
// rsp_      out  sorted_value[31:0] last_output    overflowed
// csr_      in   write enable, register index, 1-bit data
//
// Per key with n held, landing at p: accept, binary search probes (read, then
// compare; at most log2(n)+1), close the search, shift keys p..n-1 up and insert
// at p (no shift if p = n); the single store read port paces both. A last key
// adds readout, each result read then loaded. Reset is synchronous, active high,
// and empties the store (count cleared). A stalled result holds in the output
// register; the next key is taken while the final result of a run still waits.
module binary_insertion_sort_top
   import bis_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64,
   parameter int KEY_WIDTH    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,  // 0 descending_order, 1 signed_compare
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,  // [31:0] item_value
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,  // [31:0] sorted_value
   output logic                   rsp_tlast,
   output logic                   rsp_tuser   // [0] overflowed
);

   localparam int AW = $clog2(MAX_ELEMENTS);

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [KEY_WIDTH-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [KEY_WIDTH-1:0] mem_rd_data;

   bis_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .KEY_WIDTH    (KEY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bis_store #(
      .DEPTH (MAX_ELEMENTS),
      .WIDTH (KEY_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* design/bis_store.sv */
// Sorted key store: one write port, one read port, registered read data.
module bis_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bis_ctrl.sv */
// Insertion sequencer: binary search, shift-up, insert, then read out the run.
module bis_ctrl
   import bis_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64,
   parameter int KEY_WIDTH    = 32,
   parameter int AW           = $clog2(MAX_ELEMENTS),
   parameter int CW           = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // keys in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,
   input  logic                   req_tlast,
   // sorted run out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,
   // store port
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [KEY_WIDTH-1:0]   mem_wr_data,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   input  logic [KEY_WIDTH-1:0]   mem_rd_data
);

   localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

   state_type            state_ff, state_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 last_ff, last_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 desc_ff, sgn_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid;
   logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
   logic                 key_first;
   logic [63:0]          in_wide, out_wide;
   logic                 rsp_free;
   logic                 rsp_pop;

   // Search midpoint
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];

   // Key order: signed compare flips the sign bit
   always_comb begin
      cmp_a = key_ff;
      cmp_b = mem_rd_data;
      if (sgn_ff) begin
         cmp_a[KEY_WIDTH-1] = ~key_ff[KEY_WIDTH-1];
         cmp_b[KEY_WIDTH-1] = ~mem_rd_data[KEY_WIDTH-1];
      end
      key_first = desc_ff ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
   end

   assign in_wide  = 64'(req_tdata);
   assign out_wide = 64'(mem_rd_data);
   assign rsp_pop  = rsp_valid_ff && rsp_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
         sgn_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DESCENDING: desc_ff <= csr_wdata[0];
            CSR_SIGNED:     sgn_ff  <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Next state and store accesses
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in  = in_wide[KEY_WIDTH-1:0];
               last_in = req_tlast;
               lo_in   = '0;
               hi_in   = count_ff;
               idx_in  = '0;
               if (count_ff == FULL) begin
                  // drop the key, still emit on a last transfer
                  ovf_in   = 1'b1;
                  state_in = req_tlast ? ST_EMIT_RD : ST_IDLE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[AW-1:0];
               idx_in      = mid;
               state_in    = ST_PROBE;
            end else begin
               idx_in     = count_ff;
               wr_pend_in = 1'b0;
               state_in   = ST_SHIFT;
            end
         end

         ST_PROBE: begin
            // narrow the range; equal keys go past the probe
            if (key_first) begin
               hi_in = idx_ff;
            end else begin
               lo_in = idx_ff + 1'b1;
            end
            state_in = ST_SEARCH;
         end

         ST_SHIFT: begin
            // finish the move read in the previous cycle
            if (wr_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_addr_ff;
               mem_wr_data = mem_rd_data;
            end
            if (idx_ff > lo_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(idx_ff - 1'b1);
               wr_pend_in  = 1'b1;
               wr_addr_in  = idx_ff[AW-1:0];
               idx_in      = idx_ff - 1'b1;
            end else if (wr_pend_ff) begin
               wr_pend_in = 1'b0;
            end else begin
               // drop the key into the gap
               mem_wr_en   = 1'b1;
               mem_wr_addr = lo_ff[AW-1:0];
               mem_wr_data = key_ff;
               count_in    = count_ff + 1'b1;
               idx_in      = '0;
               state_in    = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end

         ST_EMIT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff[AW-1:0];
            state_in    = ST_EMIT_LD;
         end

         ST_EMIT_LD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_wide[DATA_W-1:0];
               rsp_last_in  = (idx_ff + 1'b1) == count_ff;
               rsp_user_in  = ovf_ff;
               if ((idx_ff + 1'b1) == count_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* design/bis_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the sorter.
module bis_checker
   import bis_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast,
   input logic              rsp_tuser
);

   // A stalled result holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // No key is taken while a run is still being read out
   `CHK_ASSERT(a_no_req_mid_run, clock, reset, rsp_tvalid && !rsp_tlast |-> !req_tready)

   // The overflow flag is the same on every result of a run
   `CHK_ASSERT(a_ovf_steady, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid || (rsp_tuser == $past(rsp_tuser)))

   // Reset leaves the output empty
   `CHK_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind binary_insertion_sort_top bis_checker u_bis_checker (.*);
